FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// When ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned StatusW = 2;

  localparam logic [DataW-1:0] StartMark  = 8'h3A;
  localparam logic [TickW-1:0] TimeoutRst = 16'd200;

  // configuration register indexes
  localparam logic CfgDevNum  = 1'b0;
  localparam logic CfgTimeout = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StPayload = 2'd0,
    StCkErr   = 2'd1,
    StShort   = 2'd2
  } status_e;

  // what the word just taken does to the frame
  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvShort = 2'd1,
    EvCkErr = 2'd2,
    EvRun   = 2'd3
  } evt_e;

  typedef struct packed {
    logic take;       // input word accepted
    logic load_err;   // load error result into output register
    logic rd_init;    // point read pointer at first payload byte
    logic rd_issue;   // registered memory read at read pointer
    logic load_data;  // load read data into output register
    logic rd_next;    // advance read pointer
  } ctrl_cmd_t;

  typedef struct packed {
    evt_e evt;
    logic out_free;   // output register empty or being taken
    logic rd_last;    // read pointer at final payload byte
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfr_in_if.sv
`default_nettype none

interface sfr_in_if
  import sfr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [DataW-1:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfr_out_if.sv
`default_nettype none

interface sfr_out_if
  import sfr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [DataW-1:0]   data_byte;
  logic               last;

  modport source (output valid, output status, output data_byte, output last, input ready);
  modport sink   (input valid, input status, input data_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfr_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module sfr_ctrl
  import sfr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire dp_sts_t   sts_i,
  output logic           in_ready_o,
  output ctrl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SRead = 3'b010,
    SLoad = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == SIdle) && sts_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.take = take;
    case (state_q)
      SIdle: begin
        if (take) begin
          if (sts_i.evt == EvShort || sts_i.evt == EvCkErr) begin
            cmd_o.load_err = 1'b1;
          end else if (sts_i.evt == EvRun) begin
            cmd_o.rd_init = 1'b1;
            state_d       = SRead;
          end
        end
      end
      SRead: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = SLoad;
      end
      SLoad: begin
        if (sts_i.out_free) begin
          cmd_o.load_data = 1'b1;
          if (sts_i.rd_last) begin
            state_d = SIdle;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = SRead;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_run_starts_drain, take && sts_i.evt == EvRun, state_q == SRead)
  `ASSERT_ALWAYS(a_no_take_in_drain, state_q == SIdle || !take)
  `ASSERT_ALWAYS(a_state_onehot, $onehot(state_q))

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_dp.sv
`default_nettype none
`include "assert_macros.svh"

module sfr_dp
  import sfr_pkg::*;
#(
  parameter int unsigned BufSize = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_func_i,
  input  wire logic [DataW-1:0]   in_byte_i,
  input  wire logic               out_ready_i,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_sts_t                 sts_o,
  output logic                    out_valid_o,
  output status_e                 out_status_o,
  output logic [DataW-1:0]        out_data_o,
  output logic                    out_last_o
);

  localparam int unsigned AddrW = $clog2(BufSize);
  localparam int unsigned FillW = $clog2(BufSize + 1);
  localparam logic [DataW-1:0] MaxLen = DataW'(BufSize - 2);

  // config
  logic [DataW-1:0] dev_q;
  logic [TickW-1:0] timeout_q;

  // frame state
  logic [FillW-1:0] fill_q, fill_d, fill_inc;
  logic [DataW-1:0] sum_q, sum_d, sum_add;
  logic [TickW-1:0] idle_q, idle_d, idle_inc;
  logic [AddrW-1:0] len_q, len_d;
  logic [DataW-1:0] dev_byte_q, dev_byte_d;
  logic             mem_we;
  evt_e             evt;

  // frame store and readout
  logic [DataW-1:0] mem [BufSize];
  logic [DataW-1:0] rdata_q;
  logic [AddrW-1:0] rd_ptr_q;

  // output register
  logic             out_valid_q;
  status_e          out_status_q;
  logic [DataW-1:0] out_data_q;
  logic             out_last_q;
  logic             out_free;
  logic             rd_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q     <= '0;
      timeout_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDevNum:  dev_q     <= cfg_wdata_i[DataW-1:0];
        CfgTimeout: timeout_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    fill_d     = fill_q;
    sum_d      = sum_q;
    idle_d     = idle_q;
    len_d      = len_q;
    dev_byte_d = dev_byte_q;
    evt        = EvNone;
    mem_we     = 1'b0;
    idle_inc   = (&idle_q) ? idle_q : idle_q + TickW'(1);
    fill_inc   = fill_q + FillW'(1);
    sum_add    = sum_q + in_byte_i;
    if (in_func_i) begin
      idle_d = idle_inc;
      if (fill_q != '0 && idle_inc > timeout_q) begin
        fill_d = '0;
        sum_d  = '0;
      end
    end else begin
      idle_d = '0;
      if (fill_q == '0) begin
        if (in_byte_i == StartMark) begin
          fill_d = FillW'(1);
          sum_d  = '0;
        end
      end else if (fill_q == FillW'(1)) begin
        if (in_byte_i > MaxLen) begin
          fill_d = '0;
          sum_d  = '0;
        end else begin
          len_d  = in_byte_i[AddrW-1:0];
          fill_d = FillW'(2);
          sum_d  = in_byte_i;
          if (in_byte_i == '0) begin
            evt    = EvShort;
            fill_d = '0;
            sum_d  = '0;
          end
        end
      end else begin
        mem_we = 1'b1;
        fill_d = fill_inc;
        sum_d  = sum_add;
        if (fill_q == FillW'(2)) begin
          dev_byte_d = in_byte_i;
        end
        if (fill_inc == FillW'(len_q) + FillW'(2)) begin
          fill_d = '0;
          sum_d  = '0;
          if (len_q < AddrW'(3)) begin
            evt = EvShort;
          end else if (sum_add != '0) begin
            evt = EvCkErr;
          end else if (dev_byte_q == dev_q) begin
            evt = EvRun;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      idle_q <= '0;
    end else if (cmd_i.take) begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
      idle_q <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      len_q      <= len_d;
      dev_byte_q <= dev_byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && mem_we) begin
      mem[fill_q[AddrW-1:0]] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_init) begin
      rd_ptr_q <= AddrW'(3);
    end else if (cmd_i.rd_next) begin
      rd_ptr_q <= rd_ptr_q + AddrW'(1);
    end
  end

  assign rd_last  = (rd_ptr_q == len_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_err || cmd_i.load_data) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      out_status_q <= (evt == EvShort) ? StShort : StCkErr;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.load_data) begin
      out_status_q <= StPayload;
      out_data_q   <= rdata_q;
      out_last_q   <= rd_last;
    end
  end

  assign sts_o.evt      = evt;
  assign sts_o.out_free = out_free;
  assign sts_o.rd_last  = rd_last;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

  `ASSERT_ALWAYS(a_fill_bound, fill_q <= FillW'(BufSize))
  `ASSERT_ALWAYS(a_load_needs_room, !(cmd_i.load_err || cmd_i.load_data) || out_free)
  `ASSERT_ALWAYS(a_rd_in_payload, !cmd_i.rd_issue || (rd_ptr_q >= AddrW'(3) && rd_ptr_q <= len_q))

endmodule

`default_nettype wire

FILE: hw/rtl/serial_frame_receiver_core.sv
`default_nettype none
// Channel  Dir  Fields                          Word
// in_i     in   func, rx_byte                   one received byte or one timer tick
// out_o    out  status, data_byte, last         one payload byte or one error status
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i  device number (0), timeout ticks (1)
//
// A byte or tick word is taken while the sequencer is idle and the output register
// is free. A good frame for this device then drains its payload (length minus two
// words) word by word: a registered frame store read, then the output register load;
// no input is taken during the drain. Stalls on out_o hold the output register and,
// through it, the input side. rst_ni is asynchronous; the frame store needs no
// clearing pass, since only bytes written by the current frame are ever read back.

module serial_frame_receiver_core
  import sfr_pkg::*;
#(
  parameter int unsigned BufSize = 64  // frame store depth, 8..64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  sfr_in_if.sink               in_i,
  sfr_out_if.source            out_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;
  status_e   out_status;

  // sequencer: accepts words, steps the payload drain
  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  // frame tracking, checksum, timeout, frame store and output register
  sfr_dp #(
    .BufSize (BufSize)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_func_i    (in_i.func),
    .in_byte_i    (in_i.rx_byte),
    .out_ready_i  (out_o.ready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_status),
    .out_data_o   (out_o.data_byte),
    .out_last_o   (out_o.last)
  );

  assign in_i.ready   = in_ready;
  assign out_o.status = out_status;

endmodule

`default_nettype wire
